/* sv/run_span_to_bitmap_defines.svh */
// ---------------------------------------------------------------------------
// run_span_to_bitmap_defines
// assertion macros shared by the span painter modules
// ---------------------------------------------------------------------------
`ifndef RUN_SPAN_TO_BITMAP_DEFINES_SVH
`define RUN_SPAN_TO_BITMAP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during rst
`define RSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, clocked on clk, off during rst
`define RSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSB_ASSERT_NOW(label, ante, cons, msg)
`define RSB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* sv/rsb_pkg.sv */
// ---------------------------------------------------------------------------
// rsb_pkg
// shared constants, operation codes and control structs of the span painter
// ---------------------------------------------------------------------------
`default_nettype none

package rsb_pkg;

  localparam int MAX_ROW_BYTES = 32;
  localparam int MAX_ROWS      = 256;
  localparam int STORE_DEPTH   = MAX_ROW_BYTES * MAX_ROWS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int RB_W          = 6;
  localparam int ROWS_W        = 9;
  localparam int BPTR_W        = 5;

  localparam logic [ROWS_W-1:0] ROW_LIMIT = 9'd511;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_PAINT = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [0:0] CFG_ROW_BYTES = 1'd0;
  localparam logic [0:0] CFG_ROWS      = 1'd1;

  typedef struct packed {
    logic clr_start;
    logic clr_full;
    logic clr_write;
    logic set_row;
    logic load_run;
    logic setup;
    logic paint_rd;
    logic paint_wr;
    logic byte_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic paint_ok;
    logic last_byte;
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

/* sv/rsb_ctrl.sv */
// ---------------------------------------------------------------------------
// rsb_ctrl
// sequencer for clear sweeps, line starts, span painting and byte reads
// ---------------------------------------------------------------------------
`default_nettype none
`include "run_span_to_bitmap_defines.svh"

module rsb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      operation,
  input  wire logic            out_ready,
  input  rsb_pkg::status_t     status,
  output rsb_pkg::cmd_t        cmd
);
  import rsb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_PAINT_RD,
    S_PAINT_WR,
    S_READ_WAIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // a read waits until the result slot is free or draining
  assign in_ready = (state == S_IDLE) &&
                    ((operation != OP_READ) || !status.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.clr_start = (state == S_INIT) || (accept && (operation == OP_CLEAR));
    cmd.clr_full  = (state == S_INIT);
    cmd.clr_write = (state == S_CLEAR) && !status.clr_done;
    cmd.set_row   = accept && (operation == OP_LINE);
    cmd.load_run  = accept && (operation == OP_PAINT);
    cmd.setup     = (state == S_SETUP);
    cmd.paint_rd  = (state == S_PAINT_RD);
    cmd.paint_wr  = (state == S_PAINT_WR);
    cmd.byte_step = (state == S_PAINT_WR) && !status.last_byte;
    cmd.out_load  = (state == S_READ_WAIT);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        if (status.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_CLEAR: state_next = S_CLEAR;
            OP_PAINT: state_next = S_SETUP;
            OP_READ:  state_next = S_READ_WAIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SETUP: begin
        state_next = status.paint_ok ? S_PAINT_RD : S_IDLE;
      end
      S_PAINT_RD: begin
        state_next = S_PAINT_WR;
      end
      S_PAINT_WR: begin
        state_next = status.last_byte ? S_IDLE : S_PAINT_RD;
      end
      S_READ_WAIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  `RSB_ASSERT_NEXT(a_read_lands, accept && (operation == OP_READ), state == S_READ_WAIT, "read transaction did not reach result stage")
  `RSB_ASSERT_NOW(a_wr_after_rd, state == S_PAINT_WR, $past(state) == S_PAINT_RD, "paint write without preceding read")
  `RSB_ASSERT_NEXT(a_paint_setup, accept && (operation == OP_PAINT), state == S_SETUP, "paint transaction skipped setup")

endmodule

`default_nettype wire

/* sv/rsb_datapath.sv */
// ---------------------------------------------------------------------------
// rsb_datapath
// configuration, row pointer, span clipping, raster memory and result slot
// ---------------------------------------------------------------------------
`default_nettype none
`include "run_span_to_bitmap_defines.svh"

module rsb_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [rsb_pkg::ROWS_W-1:0]    cfg_data,
  input  wire logic [7:0]                    start_row,
  input  wire logic [7:0]                    end_col,
  input  wire logic [7:0]                    run_length,
  input  wire logic [rsb_pkg::ADDR_W-1:0]    byte_index,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [7:0]                         read_data,
  input  rsb_pkg::cmd_t                      cmd,
  output rsb_pkg::status_t                   status
);
  import rsb_pkg::*;

  logic [RB_W-1:0]   row_bytes;
  logic [ROWS_W-1:0] rows;
  logic [ROWS_W-1:0] current_row;

  logic [RB_W-1:0]   rb_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic [CNT_W-1:0]  clr_prod;
  logic [CNT_W-1:0]  clr_cnt;
  logic [CNT_W-1:0]  clr_limit;

  logic [7:0]        end_col_r;
  logic [7:0]        run_len_r;
  logic [8:0]        first;
  logic [7:0]        lo;
  logic [8:0]        width;
  logic [8:0]        hi;
  logic [8:0]        hi_m1;
  logic              row_ok;
  logic [CNT_W-1:0]  base_prod;

  logic [ADDR_W-1:0] base;
  logic [BPTR_W-1:0] first_byte;
  logic [BPTR_W-1:0] last_byte;
  logic [2:0]        lo_bit;
  logic [2:0]        hi_bit;
  logic [BPTR_W-1:0] byte_ptr;
  logic [ADDR_W-1:0] paint_addr;
  logic [2:0]        mask_lo;
  logic [3:0]        mask_hi;
  logic [7:0]        mask;

  logic [7:0]        mem [STORE_DEPTH];
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        rdata;

  // effective sizes
  assign rb_eff   = (row_bytes > RB_W'(MAX_ROW_BYTES)) ? RB_W'(MAX_ROW_BYTES) : row_bytes;
  assign rows_eff = (rows > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows;
  assign clr_prod = CNT_W'(rb_eff) * CNT_W'(rows_eff);

  // span clipping
  assign first     = {1'b0, end_col_r} - {1'b0, run_len_r};
  assign lo        = first[8] ? 8'd0 : first[7:0];
  assign width     = {rb_eff, 3'b000};
  assign hi        = ({1'b0, end_col_r} < width) ? {1'b0, end_col_r} : width;
  assign hi_m1     = hi - 9'd1;
  assign row_ok    = current_row < rows_eff;
  assign base_prod = CNT_W'(current_row[7:0]) * CNT_W'(rb_eff);

  // byte mask
  assign paint_addr = base + ADDR_W'(byte_ptr);
  assign mask_lo    = (byte_ptr == first_byte) ? lo_bit : 3'd0;
  assign mask_hi    = (byte_ptr == last_byte) ? ({1'b0, hi_bit} + 4'd1) : 4'd8;
  assign mask       = (8'hff >> mask_lo) & ~(8'hff >> mask_hi);

  assign mem_we    = cmd.clr_write || cmd.paint_wr;
  assign mem_wdata = cmd.clr_write ? 8'd0 : (rdata | mask);

  always_comb begin
    if (cmd.clr_write) begin
      mem_addr = clr_cnt[ADDR_W-1:0];
    end else if (cmd.paint_rd || cmd.paint_wr) begin
      mem_addr = paint_addr;
    end else begin
      mem_addr = byte_index;
    end
  end

  assign status.clr_done  = (clr_cnt == clr_limit);
  assign status.paint_ok  = row_ok && ({1'b0, lo} < hi);
  assign status.last_byte = (byte_ptr == last_byte);
  assign status.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= RB_W'(MAX_ROW_BYTES);
      rows        <= ROWS_W'(MAX_ROWS);
      current_row <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROW_BYTES: row_bytes <= cfg_data[RB_W-1:0];
          CFG_ROWS:      rows      <= cfg_data;
          default:       rows      <= rows;
        endcase
      end
      if (cmd.set_row) begin
        current_row <= {1'b0, start_row};
      end else if (cmd.setup && (current_row != ROW_LIMIT)) begin
        current_row <= current_row + 9'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      clr_cnt   <= '0;
      clr_limit <= cmd.clr_full ? CNT_W'(STORE_DEPTH) : clr_prod;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + CNT_W'(1);
    end
    if (cmd.load_run) begin
      end_col_r <= end_col;
      run_len_r <= run_length;
    end
    if (cmd.setup) begin
      base       <= base_prod[ADDR_W-1:0];
      first_byte <= lo[7:3];
      last_byte  <= hi_m1[7:3];
      lo_bit     <= lo[2:0];
      hi_bit     <= hi_m1[2:0];
      byte_ptr   <= lo[7:3];
    end else if (cmd.byte_step) begin
      byte_ptr <= byte_ptr + BPTR_W'(1);
    end
    if (cmd.out_load) begin
      read_data <= rdata;
    end
  end

  `RSB_ASSERT_NOW(a_slot_free, cmd.out_load, !out_valid, "result loaded into occupied slot")
  `RSB_ASSERT_NOW(a_clr_bound, cmd.clr_write, clr_cnt < clr_limit, "clear sweep past its limit")
  `RSB_ASSERT_NOW(a_paint_bound, cmd.paint_wr, CNT_W'(paint_addr) < clr_prod, "paint write outside active raster")

endmodule

`default_nettype wire

/* sv/run_span_to_bitmap.sv */
// ---------------------------------------------------------------------------
// run_span_to_bitmap
// paints black runs into a packed one-bit raster and reads raster bytes back
// ---------------------------------------------------------------------------
// usage:
//   cfg_write/cfg_index/cfg_data set row_bytes (index 0) and rows (index 1);
//   the user sets them only while the block is idle, the block does not enforce
//   it. items arrive on in_valid/in_ready with the operation and its fields; a
//   transaction completes when both are high. read items return one byte on
//   out_valid/out_ready via read_data; other items return nothing.
// item handling, set by the single-port raster memory: a paint reads then
//   writes each touched byte in turn, and a clear zeroes row_bytes * rows
//   bytes, one byte cleared per cycle.
// reset: row pointer goes to zero, sizes to 32 bytes by 256 rows, and a
//   clearing pass zeroes all 8192 bytes with in_ready low.
// stall: the result stays in its output register while out_ready is low;
//   non-read items are still taken, a further read waits for the slot.
// ---------------------------------------------------------------------------
`default_nettype none

module run_span_to_bitmap (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [rsb_pkg::ROWS_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    operation,
  input  wire logic [7:0]                    start_row,
  input  wire logic [7:0]                    end_col,
  input  wire logic [7:0]                    run_length,
  input  wire logic [rsb_pkg::ADDR_W-1:0]    byte_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         read_data
);
  import rsb_pkg::*;

  cmd_t    cmd;
  status_t status;

  rsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rsb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_row  (start_row),
    .end_col    (end_col),
    .run_length (run_length),
    .byte_index (byte_index),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .read_data  (read_data),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives clear, line, paint and read transactions into run_span_to_bitmap
// under random stalls on both channels and several raster sizes, keeps its
// own copy of the raster and row counter, and compares every byte read back
// ---------------------------------------------------------------------------
module testbench;
  import rsb_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 8300;
  localparam int PHASE_ITEMS    = 130;

  class raster_tracker;
    bit [7:0]        raster [STORE_DEPTH];
    bit [ROWS_W-1:0] row_now;
    bit [RB_W-1:0]   row_bytes_reg;
    bit [ROWS_W-1:0] rows_reg;
    bit [7:0]        pending_bytes [$];
    int              errors;

    function new();
      foreach (raster[i]) raster[i] = '0;
      row_now       = '0;
      row_bytes_reg = 6'd32;
      rows_reg      = 9'd256;
      errors        = 0;
    endfunction

    function int eff_row_bytes();
      return (row_bytes_reg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_bytes_reg);
    endfunction

    function int eff_rows();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function void set_reg(logic [0:0] index, logic [ROWS_W-1:0] value);
      if (index == CFG_ROW_BYTES) begin
        row_bytes_reg = value[RB_W-1:0];
      end else begin
        rows_reg = value;
      end
    endfunction

    function void paint(int end_c, int len);
      int rb, width, base, c;
      rb = eff_row_bytes();
      width = rb * 8;
      if (int'(row_now) >= eff_rows()) return;
      base = int'(row_now) * rb;
      for (c = end_c - len; c < end_c; c++) begin
        if (c < 0) continue;
        if (c >= width) break;
        if (base + c / 8 < STORE_DEPTH) raster[base + c / 8] |= 8'h80 >> (c % 8);
      end
    endfunction

    // note one accepted input transaction
    function void take_item(logic [1:0] op, logic [7:0] srow, logic [7:0] ecol,
                            logic [7:0] len, logic [ADDR_W-1:0] idx);
      int n, i;
      case (op)
        OP_CLEAR: begin
          n = eff_row_bytes() * eff_rows();
          if (n > STORE_DEPTH) n = STORE_DEPTH;
          for (i = 0; i < n; i++) raster[i] = '0;
        end
        OP_LINE: begin
          row_now = srow;
        end
        OP_PAINT: begin
          paint(int'(ecol), int'(len));
          if (row_now < ROW_LIMIT) row_now++;
        end
        default: begin
          pending_bytes.push_back(raster[idx]);
        end
      endcase
    endfunction

    // check one accepted output transaction
    function void match_byte(logic [7:0] data);
      bit [7:0] want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected read_data: expected none actual %02h", $time, data);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (data !== want) begin
          $display("%0t: read_data mismatch: expected %02h actual %02h", $time, want, data);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [0:0]        cfg_index;
  logic [ROWS_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        operation;
  logic [7:0]        start_row;
  logic [7:0]        end_col;
  logic [7:0]        run_length;
  logic [ADDR_W-1:0] byte_index;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        read_data;

  raster_tracker tracker;
  int            send_idle;
  int            recv_idle;
  int            items_sent;

  run_span_to_bitmap dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .start_row  (start_row),
    .end_col    (end_col),
    .run_length (run_length),
    .byte_index (byte_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_item(input logic [1:0] op, input logic [7:0] srow,
                           input logic [7:0] ecol, input logic [7:0] len,
                           input logic [ADDR_W-1:0] idx);
    operation  <= op;
    start_row  <= srow;
    end_col    <= ecol;
    run_length <= len;
    byte_index <= idx;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(op, srow, ecol, len, idx);
    items_sent++;
    if (items_sent < 480) begin
      send_idle = 9;
      recv_idle = 81;
    end else if (items_sent < 960) begin
      send_idle = 81;
      recv_idle = 9;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic idle_until_drained(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_bytes.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_regs(input logic [ROWS_W-1:0] rb_value,
                          input logic [ROWS_W-1:0] rows_value);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROW_BYTES;
    cfg_data  <= rb_value;
    @(posedge clk);
    tracker.set_reg(CFG_ROW_BYTES, rb_value);
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows_value;
    @(posedge clk);
    tracker.set_reg(CFG_ROWS, rows_value);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] raster_addr(input int row, input int rb);
    if (rb == 0) return ADDR_W'($urandom_range(STORE_DEPTH - 1));
    return ADDR_W'(row * rb + $urandom_range(rb - 1));
  endfunction

  task automatic run_phase(input int n_items);
    int first, sel, count, row, rb, nrows, width;
    first = items_sent;
    while (items_sent - first < n_items) begin
      rb    = tracker.eff_row_bytes();
      nrows = tracker.eff_rows();
      width = rb * 8;
      sel   = $urandom_range(99);
      if (sel < 60) begin
        // line start, a short stroke, then reads of the touched rows
        row = (nrows == 0 || $urandom_range(4) == 0) ? $urandom_range(255)
                                                     : $urandom_range(nrows - 1);
        send_item(OP_LINE, row, $urandom_range(255), $urandom_range(255),
                  $urandom_range(STORE_DEPTH - 1));
        count = $urandom_range(1, 6);
        repeat (count) begin
          send_item(OP_PAINT, $urandom_range(255),
                    ($urandom_range(4) == 0) ? $urandom_range(255)
                      : $urandom_range((width + 16 > 255) ? 255 : width + 16),
                    ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(20),
                    $urandom_range(STORE_DEPTH - 1));
        end
        repeat ($urandom_range(1, 3)) begin
          send_item(OP_READ, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                    raster_addr(row + $urandom_range(count - 1), rb));
        end
      end else if (sel < 75) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(OP_READ, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                    raster_addr($urandom_range((nrows == 0) ? 255 : nrows - 1), rb));
        end
      end else if (sel < 87) begin
        send_item($urandom_range(3), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(STORE_DEPTH - 1));
      end else if (sel < 96) begin
        // paints with no line start
        repeat ($urandom_range(1, 3)) begin
          send_item(OP_PAINT, $urandom_range(255), $urandom_range(255),
                    $urandom_range(40), $urandom_range(STORE_DEPTH - 1));
        end
      end else if (rb * nrows <= 1024 || $urandom_range(3) == 0) begin
        send_item(OP_CLEAR, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(STORE_DEPTH - 1));
      end else begin
        send_item(OP_READ, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(STORE_DEPTH - 1));
      end
    end
  endtask

  // output side: random backpressure, checks each output transaction
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) tracker.match_byte(read_data);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** run_span_to_bitmap: FAILED **");
    $finish;
  end

  initial begin
    int p, k;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = CFG_ROW_BYTES;
    cfg_data   = '0;
    in_valid   = 1'b0;
    operation  = OP_CLEAR;
    start_row  = '0;
    end_col    = '0;
    run_length = '0;
    byte_index = '0;
    tracker    = new;
    send_idle  = 9;
    recv_idle  = 81;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, default 32 x 256 raster
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_LINE, 0, 0, 0, 0);
    send_item(OP_PAINT, 0, 8'd8, 8'd8, 0);
    send_item(OP_PAINT, 0, 8'd3, 8'd5, 0);
    send_item(OP_PAINT, 0, 8'd255, 8'd255, 0);
    send_item(OP_PAINT, 0, 8'd10, 8'd0, 0);
    send_item(OP_READ, 0, 0, 0, 13'd32);
    send_item(OP_READ, 0, 0, 0, 13'd95);
    send_item(OP_READ, 0, 0, 0, 13'd96);
    send_item(OP_LINE, 8'd255, 0, 0, 0);
    send_item(OP_PAINT, 0, 8'd255, 8'd1, 0);
    send_item(OP_READ, 0, 0, 0, 13'h1fff);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    run_phase(PHASE_ITEMS);

    for (p = 1; p < 9; p++) begin
      idle_until_drained(SETTLE_CYCLES);
      case (p)
        1: set_regs({3'b101, 6'd4}, 9'd16);
        2: set_regs(9'd1, 9'd1);
        3: set_regs(9'h1ff, 9'h1ff);
        4: set_regs(9'd0, 9'd9);
        5: set_regs({3'b010, 6'd12}, 9'd0);
        6: set_regs(9'd1, 9'd256);
        7: set_regs(9'd32, 9'd1);
        default: set_regs($urandom_range(511), $urandom_range(511));
      endcase
      if (p == 1) begin
        // width clipping and the last active row
        send_item(OP_LINE, 8'd3, 0, 0, 0);
        send_item(OP_PAINT, 0, 8'd255, 8'd255, 0);
        send_item(OP_READ, 0, 0, 0, 13'd15);
        send_item(OP_READ, 0, 0, 0, 13'd16);
        send_item(OP_LINE, 8'd15, 0, 0, 0);
        send_item(OP_PAINT, 0, 8'd8, 8'd8, 0);
        send_item(OP_PAINT, 0, 8'd8, 8'd8, 0);
        send_item(OP_READ, 0, 0, 0, 13'd60);
        send_item(OP_READ, 0, 0, 0, 13'd64);
      end
      if (p == 3) begin
        // row counter should hold at its top value, never wrap to row 0
        send_item(OP_CLEAR, 0, 0, 0, 0);
        send_item(OP_LINE, 8'd255, 0, 0, 0);
        repeat (258) begin
          send_item(OP_PAINT, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(STORE_DEPTH - 1));
        end
        send_item(OP_PAINT, 0, 8'd8, 8'd8, 0);
        for (k = 0; k < 4; k++) send_item(OP_READ, 0, 0, 0, ADDR_W'(k * 32));
      end
      if (p == 2) begin
        run_phase(PHASE_ITEMS / 2);
        idle_until_drained(0);
        run_phase(PHASE_ITEMS / 2);
      end else begin
        run_phase(PHASE_ITEMS);
      end
    end

    idle_until_drained(200);
    if (tracker.errors == 0 && tracker.pending_bytes.size() == 0) begin
      $display("** run_span_to_bitmap: PASSED **");
    end else begin
      $display("** run_span_to_bitmap: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/rsb_pkg.sv
sv/rsb_ctrl.sv
sv/rsb_datapath.sv
sv/run_span_to_bitmap.sv
sim/testbench.sv
